// ----- rtl/core/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Types and constants shared by the double-ended queue core: request and
// result word layouts, request codes, status codes and controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    // Field widths fixed by the word formats.
    localparam int VALUE_W = 32;
    localparam int REQ_W   = 2;
    localparam int FILL_W  = 5;
    localparam int STAT_W  = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // One request word.
    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic signed [VALUE_W-1:0] push_value;
    } req_item_t;

    // One result word.
    typedef struct packed {
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] back_value;
        logic [FILL_W-1:0]         fill_count;
        logic [STAT_W-1:0]         status;
    } rsp_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic apply;   // Carry out the accepted request on the ring.
        logic load;    // Capture the ends, count and status into the result.
    } deq_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/double_ended_queue_core.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed 32-bit values in a ring memory.
// ----------------------------------------------------------------------------
// Each request word pushes at the back, pushes at the front, pops the front
// or pops the back, and produces one result word with both end values (zero
// when empty), the fill count and a status (done, push rejected because
// full, pop ignored because empty). After acceptance the pointers update and
// the ring is written, both ends are then read from the ring memory into
// registers, and the result register is loaded once it is free, that is
// empty or being drained. The next request is accepted once the result is
// loaded, even if that result has not yet been taken. Store contents need no
// clearing after reset. The fill count on the result is the low five bits of
// the stored count.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_core #(
    parameter int DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire deq_pkg::req_item_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output deq_pkg::rsp_item_t      rsp
);

    deq_pkg::deq_cmd_t cmd;

    // Sequencer.
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    // Pointers, ring memory and result register.
    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ----- rtl/core/deq_ram.sv -----
// ----------------------------------------------------------------------------
// deq_ram
// Generic memory with one write port and two read ports. Read data is
// registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ----- rtl/core/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer for the double-ended queue. It accepts one request word, waits
// for the ring memory to read both ends, then loads the result register once
// it is free and keeps its valid flag until the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output deq_pkg::deq_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       valid_reg;
    logic       valid_next;
    logic       out_free;

    // The result register can take a new word when empty or being drained.
    assign out_free  = !valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = valid_reg;

    // Next-state and command logic.
    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg && rsp_stall;
        cmd.apply  = 1'b0;
        cmd.load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load   = 1'b1;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/deq_datapath.sv -----
// ----------------------------------------------------------------------------
// deq_datapath
// Ring pointers, fill count and ring memory of the double-ended queue, plus
// the result register that presents both ends after each request.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_datapath #(
    parameter int DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire deq_pkg::deq_cmd_t   cmd,
    input  wire deq_pkg::req_item_t  req,
    output deq_pkg::rsp_item_t       rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [IDX_W-1:0]           front_reg;
    logic [IDX_W-1:0]           front_next;
    logic [IDX_W-1:0]           back_reg;
    logic [IDX_W-1:0]           back_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [deq_pkg::STAT_W-1:0] stat_reg;
    logic [deq_pkg::STAT_W-1:0] stat_next;
    logic [IDX_W-1:0]           front_succ;
    logic [IDX_W-1:0]           front_pred;
    logic [IDX_W-1:0]           back_succ;
    logic [IDX_W-1:0]           back_pred;
    logic                       is_empty;
    logic                       is_full;
    logic                       is_push;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [deq_pkg::VALUE_W-1:0] rd_front;
    logic [deq_pkg::VALUE_W-1:0] rd_back;
    deq_pkg::rsp_item_t         rsp_reg;

    // Ring steps with wrap at the end of the store.
    assign front_succ = (front_reg == IDX_LAST) ? '0 : front_reg + 1'b1;
    assign front_pred = (front_reg == '0) ? IDX_LAST : front_reg - 1'b1;
    assign back_succ  = (back_reg == IDX_LAST) ? '0 : back_reg + 1'b1;
    assign back_pred  = (back_reg == '0) ? IDX_LAST : back_reg - 1'b1;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_FULL);
    assign is_push  = (req.req_type == deq_pkg::REQ_PUSH_BACK)
                   || (req.req_type == deq_pkg::REQ_PUSH_FRONT);

    // Pointer, count and write updates for one request.
    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        stat_next  = stat_reg;
        wr_en      = 1'b0;
        wr_addr    = front_reg;
        if (cmd.apply)
        begin
            stat_next = deq_pkg::ST_DONE;
            if (is_push)
            begin
                if (is_full)
                begin
                    stat_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (is_empty)
                    begin
                        back_next = front_reg;
                        wr_addr   = front_reg;
                    end
                    else if (req.req_type == deq_pkg::REQ_PUSH_BACK)
                    begin
                        back_next = back_succ;
                        wr_addr   = back_succ;
                    end
                    else
                    begin
                        front_next = front_pred;
                        wr_addr    = front_pred;
                    end
                end
            end
            else
            begin
                if (is_empty)
                begin
                    stat_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNT_ONE)
                    begin
                        back_next = front_reg;
                    end
                    else if (req.req_type == deq_pkg::REQ_POP_FRONT)
                    begin
                        front_next = front_succ;
                    end
                    else
                    begin
                        back_next = back_pred;
                    end
                end
            end
        end
    end

    // Control state: pointers, count and last status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
            stat_reg  <= deq_pkg::ST_DONE;
        end
        else
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
            stat_reg  <= stat_next;
        end
    end

    // Ring store; both ends are read continuously at the current pointers.
    deq_ram #(
        .WIDTH (deq_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (req.push_value),
        .rd_addr_a (front_reg),
        .rd_addr_b (back_reg),
        .rd_data_a (rd_front),
        .rd_data_b (rd_back)
    );

    // Result register; an empty deque shows zero at both ends.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rsp_reg.front_value <= is_empty ? '0 : rd_front;
            rsp_reg.back_value  <= is_empty ? '0 : rd_back;
            rsp_reg.fill_count  <= deq_pkg::FILL_W'(count_reg);
            rsp_reg.status      <= stat_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ----- dv/tb_double_ended_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_core
// Self-checking bench for the double-ended queue core.
// ----------------------------------------------------------------------------
// A short table of directed request words covers the empty and full corners,
// the value extremes and the removal of the last value. A long random run
// follows, in segments that lean toward pushes or pops so that the ring
// fills, drains and wraps many times. Each accepted request word is run
// through a local model of the ring, and every result word is compared field
// by field with the oldest prediction. The request side sends in bursts with
// idle gaps, and the result side stalls on its own changing pattern.
// ----------------------------------------------------------------------------

module tb_double_ended_queue_core;

    localparam int DEPTH       = 16;
    localparam int RAND_WORDS  = 700;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 12;

    // One row of the directed table; the result is typed in only when known.
    typedef struct {
        deq_pkg::req_item_t word;
        bit                 typed;
        deq_pkg::rsp_item_t want;
    } table_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    deq_pkg::req_item_t req       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    deq_pkg::rsp_item_t rsp;

    // Local copy of the ring and its pointers.
    logic signed [deq_pkg::VALUE_W-1:0] ring_mem [DEPTH];
    int unsigned               head_pos  = 0;
    int unsigned               tail_pos  = 0;
    int unsigned               held_cnt  = 0;

    deq_pkg::rsp_item_t due_results [$];
    table_row_t         corner_rows [$];
    int unsigned cycle_cnt   = 0;
    int unsigned fail_cnt    = 0;
    int unsigned burst_left  = 0;

    double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    // Free-running clock, 10 ns period.
    always #5 clk = ~clk;

    // Count cycles for the run limit.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Apply one request word to the ring model and return the result word.
    function automatic deq_pkg::rsp_item_t deque_apply(input deq_pkg::req_item_t word);
        deq_pkg::rsp_item_t         res;
        logic [deq_pkg::STAT_W-1:0] stat;
        stat = deq_pkg::ST_DONE;
        if (word.req_type == deq_pkg::REQ_PUSH_BACK
            || word.req_type == deq_pkg::REQ_PUSH_FRONT)
        begin
            if (held_cnt >= DEPTH)
            begin
                stat = deq_pkg::ST_FULL;
            end
            else
            begin
                // The first value sits at the head; later ones extend one end.
                if (held_cnt == 0)
                    tail_pos = head_pos;
                else if (word.req_type == deq_pkg::REQ_PUSH_BACK)
                    tail_pos = (tail_pos + 1) % DEPTH;
                else
                    head_pos = (head_pos + DEPTH - 1) % DEPTH;
                if (word.req_type == deq_pkg::REQ_PUSH_BACK)
                    ring_mem[tail_pos] = word.push_value;
                else
                    ring_mem[head_pos] = word.push_value;
                held_cnt++;
            end
        end
        else
        begin
            if (held_cnt == 0)
            begin
                stat = deq_pkg::ST_EMPTY;
            end
            else
            begin
                // Removing the last value collapses both pointers together.
                if (held_cnt == 1)
                    tail_pos = head_pos;
                else if (word.req_type == deq_pkg::REQ_POP_FRONT)
                    head_pos = (head_pos + 1) % DEPTH;
                else
                    tail_pos = (tail_pos + DEPTH - 1) % DEPTH;
                held_cnt--;
            end
        end
        if (held_cnt == 0)
        begin
            res.front_value = '0;
            res.back_value  = '0;
        end
        else
        begin
            res.front_value = ring_mem[head_pos];
            res.back_value  = ring_mem[tail_pos];
        end
        res.fill_count = held_cnt[deq_pkg::FILL_W-1:0];
        res.status     = stat;
        return res;
    endfunction

    // Add one row to the directed table.
    task automatic add_row(input logic [deq_pkg::REQ_W-1:0] kind,
                           input logic signed [31:0] value,
                           input bit typed, input deq_pkg::rsp_item_t want);
        table_row_t row;
        row.word.req_type   = kind;
        row.word.push_value = value;
        row.typed           = typed;
        row.want            = want;
        corner_rows.insert(corner_rows.size(), row);
    endtask

    // Send one request word with burst and gap shaping, then log its result.
    task automatic send_word(input deq_pkg::req_item_t word, input bit typed,
                             input deq_pkg::rsp_item_t want);
        int unsigned        idle;
        deq_pkg::rsp_item_t predicted;
        idle = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            idle       = $urandom_range(0, 6);
        end
        burst_left--;
        @(negedge clk);
        if (idle > 0)
        begin
            req_valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= word;
        do
            @(posedge clk);
        while (!(req_valid === 1'b1 && req_stall === 1'b0));
        predicted = deque_apply(word);
        due_results.insert(due_results.size(), typed ? want : predicted);
    endtask

    // Result stall pattern: the style is redrawn at random whenever its run ends.
    always @(negedge clk)
    begin : stall_gen
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        if (mode_left == 0)
        begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= (cycle_cnt % 3 == 1);
            default:
            begin
                // Long stall runs separated by short open windows.
                if (hold_left == 0)
                    hold_left = $urandom_range(1, 12);
                hold_left--;
                rsp_stall <= (hold_left > 2);
            end
        endcase
    end

    // Compare every accepted result word with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        deq_pkg::rsp_item_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result word: %p", rsp);
                fail_cnt++;
            end
            else
            begin
                want = due_results[0];
                due_results.delete(0);
                if (rsp.front_value !== want.front_value)
                begin
                    $error("front_value mismatch: expected %0d, actual %0d",
                           want.front_value, rsp.front_value);
                    fail_cnt++;
                end
                if (rsp.back_value !== want.back_value)
                begin
                    $error("back_value mismatch: expected %0d, actual %0d",
                           want.back_value, rsp.back_value);
                    fail_cnt++;
                end
                if (rsp.fill_count !== want.fill_count)
                begin
                    $error("fill_count mismatch: expected %0d, actual %0d",
                           want.fill_count, rsp.fill_count);
                    fail_cnt++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, rsp.status);
                    fail_cnt++;
                end
            end
        end
    end

    // Hard stop if the run hangs.
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // Main stimulus.
    initial
    begin : stimulus
        deq_pkg::rsp_item_t none;
        deq_pkg::req_item_t word;
        int unsigned        seg_left;
        int unsigned        push_pct;
        int unsigned        pick;
        logic signed [31:0] pat;

        none = '0;
        pat  = 32'sh5A5A_A5A5;

        // Empty-deque pops, extremes at both ends, and removal of the last value.
        add_row(deq_pkg::REQ_POP_FRONT, pat, 1'b1, '{0, 0, 5'd0, deq_pkg::ST_EMPTY});
        add_row(deq_pkg::REQ_POP_BACK, ~pat, 1'b1, '{0, 0, 5'd0, deq_pkg::ST_EMPTY});
        add_row(deq_pkg::REQ_PUSH_BACK, 32'sh7FFF_FFFF, 1'b1,
                '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'd1, deq_pkg::ST_DONE});
        add_row(deq_pkg::REQ_PUSH_FRONT, 32'sh8000_0000, 1'b1,
                '{32'sh8000_0000, 32'sh7FFF_FFFF, 5'd2, deq_pkg::ST_DONE});
        add_row(deq_pkg::REQ_POP_BACK, pat, 1'b1,
                '{32'sh8000_0000, 32'sh8000_0000, 5'd1, deq_pkg::ST_DONE});
        add_row(deq_pkg::REQ_POP_FRONT, ~pat, 1'b1, '{0, 0, 5'd0, deq_pkg::ST_DONE});
        add_row(deq_pkg::REQ_PUSH_FRONT, -32'sd1, 1'b1,
                '{-32'sd1, -32'sd1, 5'd1, deq_pkg::ST_DONE});
        // Fill to capacity from both ends, then push into the full deque.
        for (int i = 0; i < DEPTH - 1; i++)
            add_row((i % 2) ? deq_pkg::REQ_PUSH_FRONT : deq_pkg::REQ_PUSH_BACK,
                    32'(i * 32'h1111_1111), 1'b0, none);
        add_row(deq_pkg::REQ_PUSH_BACK, 32'sd0, 1'b0, none);
        add_row(deq_pkg::REQ_PUSH_FRONT, 32'sh7FFF_FFFF, 1'b0, none);
        add_row(deq_pkg::REQ_POP_FRONT, 32'sh8000_0000, 1'b0, none);

        // Hold reset, then release it away from the rising edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (corner_rows[i])
            send_word(corner_rows[i].word, corner_rows[i].typed, corner_rows[i].want);

        // Random segments lean toward pushes or pops to fill, drain and wrap.
        seg_left = 0;
        push_pct = 50;
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(8, 50);
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
            end
            seg_left--;
            if ($urandom_range(0, 99) < push_pct)
                word.req_type = $urandom_range(0, 1) ? deq_pkg::REQ_PUSH_FRONT
                                                     : deq_pkg::REQ_PUSH_BACK;
            else
                word.req_type = $urandom_range(0, 1) ? deq_pkg::REQ_POP_FRONT
                                                     : deq_pkg::REQ_POP_BACK;
            pick = $urandom_range(0, 15);
            case (pick)
                0: word.push_value = 32'sh7FFF_FFFF;
                1: word.push_value = 32'sh8000_0000;
                2: word.push_value = 32'sd0;
                3: word.push_value = -32'sd1;
                default: word.push_value = $urandom;
            endcase
            send_word(word, 1'b0, none);
        end
        @(negedge clk);
        req_valid <= 1'b0;

        // Let every outstanding result arrive, then allow the pipeline to settle.
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_cnt == 0 && due_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
